// ===== rtl/sts_pkg.sv =====
package sts_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int SLOTS_REG_W = 5;
   localparam logic [SLOTS_REG_W-1:0] SLOTS_REG_RESET = 5'd16;
   localparam logic CSR_IDX_SLOTS_IN_USE = 1'b0;

   typedef enum logic [1:0] {
      CMD_ONE_SHOT = 2'd0,
      CMD_REPEAT   = 2'd1,
      CMD_CANCEL   = 2'd2,
      CMD_DISPATCH = 2'd3
   } sts_cmd_type;

   typedef enum logic [1:0] {
      KIND_CREATE = 2'd0,
      KIND_CANCEL = 2'd1,
      KIND_FIRED  = 2'd2
   } sts_kind_type;

   typedef struct packed {
      sts_cmd_type cmd;
      logic [31:0] interval;
      logic [7:0]  action_tag;
      logic [31:0] handle;
      logic [31:0] now;
   } sts_req_type;

   typedef struct packed {
      sts_kind_type kind;
      logic [31:0]  timer_handle;
      logic [7:0]   fired_tag;
      logic         ok;
      logic         last;
   } sts_rsp_type;

   typedef struct packed {
      logic [31:0] handle;
      logic [31:0] due;
      logic [31:0] period;
      logic [7:0]  tag;
   } sts_slot_type;

   typedef struct packed {
      logic         en;
      logic         due_only;
      sts_slot_type data;
   } sts_mem_wr_type;

   typedef struct packed {
      logic [31:0] sum;
      logic        due_lt_now;
      logic        handle_eq;
   } sts_alu_res_type;

endpackage

// ===== rtl/sts_slot_mem.sv =====
module sts_slot_mem import sts_pkg::*; #(
   parameter int MAX_SLOTS = 16,
   parameter int TAG_BITS = 8,
   parameter int IDX_W = 4
) (
   input  logic           clock,
   input  sts_mem_wr_type wr,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [IDX_W-1:0] rd_idx,
   output sts_slot_type   rd
);

   localparam int TagW = (TAG_BITS < 8) ? TAG_BITS : 8;

   logic [31:0]     handle_mem_ff [MAX_SLOTS];
   logic [31:0]     due_mem_ff    [MAX_SLOTS];
   logic [31:0]     period_mem_ff [MAX_SLOTS];
   logic [TagW-1:0] tag_mem_ff    [MAX_SLOTS];

   logic [31:0]     rd_handle_ff;
   logic [31:0]     rd_due_ff;
   logic [31:0]     rd_period_ff;
   logic [TagW-1:0] rd_tag_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         due_mem_ff[wr_idx] <= wr.data.due;
         if (!wr.due_only) begin
            handle_mem_ff[wr_idx] <= wr.data.handle;
            period_mem_ff[wr_idx] <= wr.data.period;
            tag_mem_ff[wr_idx]    <= wr.data.tag[TagW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_handle_ff <= handle_mem_ff[rd_idx];
      rd_due_ff    <= due_mem_ff[rd_idx];
      rd_period_ff <= period_mem_ff[rd_idx];
      rd_tag_ff    <= tag_mem_ff[rd_idx];
   end

   assign rd.handle = rd_handle_ff;
   assign rd.due    = rd_due_ff;
   assign rd.period = rd_period_ff;
   assign rd.tag    = 8'(rd_tag_ff);

endmodule

// ===== rtl/sts_slot_alu.sv =====
module sts_slot_alu import sts_pkg::*; (
   input  logic            create,
   input  logic [31:0]     interval,
   input  logic [31:0]     cur_time,
   input  logic [31:0]     handle,
   input  sts_slot_type    slot,
   output sts_alu_res_type res
);

   logic [31:0] add_a;
   logic [31:0] add_b;

   assign add_a = create ? interval : slot.due;
   assign add_b = create ? cur_time : slot.period;

   assign res.sum        = add_a + add_b;
   assign res.due_lt_now = (slot.due < cur_time);
   assign res.handle_eq  = (slot.handle == handle);

endmodule

// ===== rtl/software_timer_slot_table.sv =====
// Timer slot table. A request is taken when start is high and busy is low;
// busy then stays high until the slot scan is finished. Create, cancel and
// dispatch all walk the active slots in order, one slot per cycle through
// the single read port of the slot memory. The scan covers at most n slots,
// where n is the active slot count, and create or cancel ends early at the
// slot it hits. The last result of a request appears in the cycle in which
// busy first reads low, and a new request can be taken in that same cycle.
// Results appear on rsp_data for exactly one cycle with rsp_valid high and
// must be taken in that cycle; the receiver cannot stall the block. A
// dispatch gives at most one fired result per cycle and none at all if no
// timer is due.
module software_timer_slot_table import sts_pkg::*; #(
   parameter int MAX_SLOTS = 16,
   parameter int TAG_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sts_req_type           req_data,
   output logic                  rsp_valid,
   output sts_rsp_type           rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int CntW = $clog2(MAX_SLOTS + 1);
   localparam int IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CmpW = (CntW > SLOTS_REG_W) ? CntW : SLOTS_REG_W;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [SLOTS_REG_W-1:0] slots_in_use_ff;
   sts_req_type      req_ff, req_in;
   logic [31:0]      time_ff, time_in;
   logic [31:0]      counter_ff, counter_in;
   logic [MAX_SLOTS-1:0] used_ff, used_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic             pv_ff, pv_in;
   logic [IdxW-1:0]  pidx_ff, pidx_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [31:0]      hold_handle_ff, hold_handle_in;
   logic [7:0]       hold_tag_ff, hold_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   sts_rsp_type      rsp_ff, rsp_in;

   logic [CmpW-1:0]  cfg_ext;
   logic [CntW-1:0]  n;
   logic             accept;
   logic             is_create;
   sts_slot_type     rd_slot;
   sts_alu_res_type  alu_res;
   sts_mem_wr_type   mem_wr;

   assign cfg_ext = CmpW'(slots_in_use_ff);

   always_comb begin
      if (cfg_ext == '0) begin
         n = CntW'(1);
      end else if (cfg_ext > CmpW'(MAX_SLOTS)) begin
         n = CntW'(MAX_SLOTS);
      end else begin
         n = CntW'(cfg_ext);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_create = (req_ff.cmd == CMD_ONE_SHOT) || (req_ff.cmd == CMD_REPEAT);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == CSR_IDX_SLOTS_IN_USE) ? 32'(slots_in_use_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_in_use_ff <= SLOTS_REG_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == CSR_IDX_SLOTS_IN_USE)) begin
         slots_in_use_ff <= pwdata[SLOTS_REG_W-1:0];
      end
   end

   sts_slot_mem #(
      .MAX_SLOTS(MAX_SLOTS),
      .TAG_BITS(TAG_BITS),
      .IDX_W(IdxW)
   ) u_mem (
      .clock(clock),
      .wr(mem_wr),
      .wr_idx(pidx_ff),
      .rd_idx(idx_ff[IdxW-1:0]),
      .rd(rd_slot)
   );

   sts_slot_alu u_alu (
      .create(is_create),
      .interval(req_ff.interval),
      .cur_time(time_ff),
      .handle(req_ff.handle),
      .slot(rd_slot),
      .res(alu_res)
   );

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      time_in        = time_ff;
      counter_in     = counter_ff;
      used_in        = used_ff;
      idx_in         = idx_ff;
      pv_in          = 1'b0;
      pidx_in        = pidx_ff;
      hold_valid_in  = hold_valid_ff;
      hold_handle_in = hold_handle_ff;
      hold_tag_in    = hold_tag_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      mem_wr         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            hold_valid_in = 1'b0;
            if (accept) begin
               req_in   = req_data;
               idx_in   = '0;
               state_in = ST_SCAN;
               if (req_data.cmd == CMD_DISPATCH) begin
                  time_in = req_data.now;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff < n) begin
               pv_in   = 1'b1;
               pidx_in = idx_ff[IdxW-1:0];
               idx_in  = idx_ff + CntW'(1);
            end
            if (pv_ff) begin
               case (req_ff.cmd) inside
                  CMD_ONE_SHOT, CMD_REPEAT: begin
                     if (!used_ff[pidx_ff]) begin
                        counter_in            = counter_ff + 32'd1;
                        used_in[pidx_ff]      = 1'b1;
                        mem_wr.en             = 1'b1;
                        mem_wr.data.handle    = counter_ff + 32'd1;
                        mem_wr.data.due       = alu_res.sum;
                        mem_wr.data.period    =
                           (req_ff.cmd == CMD_REPEAT) ? req_ff.interval : '0;
                        mem_wr.data.tag       = req_ff.action_tag;
                        rsp_valid_in          = 1'b1;
                        rsp_in.kind           = KIND_CREATE;
                        rsp_in.timer_handle   = counter_ff + 32'd1;
                        rsp_in.fired_tag      = '0;
                        rsp_in.ok             = 1'b1;
                        rsp_in.last           = 1'b1;
                        pv_in                 = 1'b0;
                        state_in              = ST_IDLE;
                     end
                  end
                  CMD_CANCEL: begin
                     if (used_ff[pidx_ff] && alu_res.handle_eq) begin
                        used_in[pidx_ff]    = 1'b0;
                        rsp_valid_in        = 1'b1;
                        rsp_in.kind         = KIND_CANCEL;
                        rsp_in.timer_handle = '0;
                        rsp_in.fired_tag    = '0;
                        rsp_in.ok           = 1'b1;
                        rsp_in.last         = 1'b1;
                        pv_in               = 1'b0;
                        state_in            = ST_IDLE;
                     end
                  end
                  default: begin
                     if (used_ff[pidx_ff] && alu_res.due_lt_now) begin
                        if (hold_valid_ff) begin
                           rsp_valid_in        = 1'b1;
                           rsp_in.kind         = KIND_FIRED;
                           rsp_in.timer_handle = hold_handle_ff;
                           rsp_in.fired_tag    = hold_tag_ff;
                           rsp_in.ok           = 1'b1;
                           rsp_in.last         = 1'b0;
                        end
                        hold_valid_in  = 1'b1;
                        hold_handle_in = rd_slot.handle;
                        hold_tag_in    = rd_slot.tag;
                        if (rd_slot.period != '0) begin
                           mem_wr.en       = 1'b1;
                           mem_wr.due_only = 1'b1;
                           mem_wr.data.due = alu_res.sum;
                        end else begin
                           used_in[pidx_ff] = 1'b0;
                        end
                     end
                  end
               endcase
            end else if (idx_ff >= n) begin
               state_in = ST_IDLE;
               case (req_ff.cmd) inside
                  CMD_ONE_SHOT, CMD_REPEAT: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.kind         = KIND_CREATE;
                     rsp_in.timer_handle = '0;
                     rsp_in.fired_tag    = '0;
                     rsp_in.ok           = 1'b1;
                     rsp_in.last         = 1'b1;
                  end
                  CMD_CANCEL: begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.kind         = KIND_CANCEL;
                     rsp_in.timer_handle = '0;
                     rsp_in.fired_tag    = '0;
                     rsp_in.ok           = 1'b0;
                     rsp_in.last         = 1'b1;
                  end
                  default: begin
                     rsp_valid_in        = hold_valid_ff;
                     rsp_in.kind         = KIND_FIRED;
                     rsp_in.timer_handle = hold_handle_ff;
                     rsp_in.fired_tag    = hold_tag_ff;
                     rsp_in.ok           = 1'b1;
                     rsp_in.last         = 1'b1;
                  end
               endcase
               hold_valid_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         time_ff       <= '0;
         counter_ff    <= '0;
         used_ff       <= '0;
         idx_ff        <= '0;
         pv_ff         <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         time_ff       <= time_in;
         counter_ff    <= counter_in;
         used_ff       <= used_in;
         idx_ff        <= idx_in;
         pv_ff         <= pv_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      pidx_ff        <= pidx_in;
      hold_handle_ff <= hold_handle_in;
      hold_tag_ff    <= hold_tag_in;
      rsp_ff         <= rsp_in;
   end

`ifndef SYNTH
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_SCAN))
      else $error("Result strobe without an active scan.");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("Accepted request did not start a scan.");

   a_pidx_in_range: assert property (@(posedge clock) disable iff (reset)
      pv_ff |-> (CntW'(pidx_ff) < n))
      else $error("Evaluated slot lies beyond the active slot count.");

   a_hold_in_scan: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (state_ff == ST_SCAN) && (req_ff.cmd == CMD_DISPATCH))
      else $error("Held fired result outside a dispatch scan.");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top import sts_pkg::*; ();

   localparam int NUM_SLOTS = 16;
   localparam int IDLE_GAP = NUM_SLOTS + 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int ITEMS_PER_PHASE = 37;
   localparam logic [CSR_ADDR_W-1:0] SLOTS_ADDR =
      CSR_ADDR_W'(4 * int'(CSR_IDX_SLOTS_IN_USE));

   typedef struct {
      logic [4:0]  slots;
      sts_req_type req;
      logic        pinned;
      sts_rsp_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   sts_req_type       req_data;
   logic              rsp_valid;
   sts_rsp_type       rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   logic              pin_valid;
   sts_rsp_type       pin_rsp;

   // Shadow copy of the slot table.
   logic              slot_live [NUM_SLOTS];
   logic [31:0]       slot_hdl [NUM_SLOTS];
   logic [31:0]       slot_due [NUM_SLOTS];
   logic [31:0]       slot_per [NUM_SLOTS];
   logic [7:0]        slot_tg [NUM_SLOTS];
   logic [31:0]       hdl_count;
   logic [31:0]       cur_time;
   logic [4:0]        slots_reg;

   sts_rsp_type       expected_q[$];
   int unsigned       mismatch_count;
   int unsigned       idle_cycles;
   stim_row_type      stim_rows[$];

   software_timer_slot_table #(
      .MAX_SLOTS(NUM_SLOTS),
      .TAG_BITS(8)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic stim_row_type row(input logic [4:0] slots, input sts_cmd_type cmd,
                                        input logic [31:0] interval, input logic [7:0] tag,
                                        input logic [31:0] hdl, input logic [31:0] now,
                                        input logic pinned, input sts_kind_type kind,
                                        input logic [31:0] rsp_hdl, input logic ok);
      stim_row_type r;
      r.slots = slots;
      r.req.cmd = cmd;
      r.req.interval = interval;
      r.req.action_tag = tag;
      r.req.handle = hdl;
      r.req.now = now;
      r.pinned = pinned;
      r.rsp.kind = kind;
      r.rsp.timer_handle = rsp_hdl;
      r.rsp.fired_tag = 8'h00;
      r.rsp.ok = ok;
      r.rsp.last = 1'b1;
      return r;
   endfunction

   function automatic void timer_table_step(input sts_req_type r);
      int unsigned n;
      int unsigned i;
      logic        hit;
      sts_rsp_type res;
      n = (slots_reg == 5'd0) ? 1 : (int'(slots_reg) > NUM_SLOTS) ? NUM_SLOTS : slots_reg;
      res = '0;
      res.ok = 1'b1;
      res.last = 1'b1;
      hit = 1'b0;
      case (r.cmd)
         CMD_ONE_SHOT, CMD_REPEAT: begin
            res.kind = KIND_CREATE;
            for (i = 0; i < n && !hit; i++) begin
               if (!slot_live[i]) begin
                  hit = 1'b1;
                  hdl_count = hdl_count + 32'd1;
                  slot_live[i] = 1'b1;
                  slot_hdl[i] = hdl_count;
                  slot_per[i] = (r.cmd == CMD_REPEAT) ? r.interval : 32'd0;
                  slot_due[i] = r.interval + cur_time;
                  slot_tg[i] = r.action_tag;
                  res.timer_handle = hdl_count;
               end
            end
            expected_q.push_back(res);
         end
         CMD_CANCEL: begin
            res.kind = KIND_CANCEL;
            for (i = 0; i < n && !hit; i++) begin
               if (slot_live[i] && slot_hdl[i] == r.handle) begin
                  hit = 1'b1;
                  slot_live[i] = 1'b0;
               end
            end
            res.ok = hit;
            expected_q.push_back(res);
         end
         default: begin
            cur_time = r.now;
            res.kind = KIND_FIRED;
            res.last = 1'b0;
            for (i = 0; i < n; i++) begin
               if (slot_live[i] && slot_due[i] < r.now) begin
                  hit = 1'b1;
                  res.timer_handle = slot_hdl[i];
                  res.fired_tag = slot_tg[i];
                  expected_q.push_back(res);
                  if (slot_per[i] != 32'd0) begin
                     slot_due[i] = slot_due[i] + slot_per[i];
                  end else begin
                     slot_live[i] = 1'b0;
                  end
               end
            end
            if (hit) begin
               res = expected_q.pop_back();
               res.last = 1'b1;
               expected_q.push_back(res);
            end
         end
      endcase
   endfunction

   function automatic void report_mismatch(input string what, input sts_rsp_type want,
                                           input sts_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s: expected kind=%0d handle=%h tag=%h ok=%b last=%b", $realtime,
                  what, want.kind, want.timer_handle, want.fired_tag, want.ok, want.last);
         $display("%0t: %s: actual   kind=%0d handle=%h tag=%h ok=%b last=%b", $realtime,
                  what, got.kind, got.timer_handle, got.fired_tag, got.ok, got.last);
      end
   endfunction

   function automatic sts_req_type random_request();
      sts_req_type r;
      int unsigned sel;
      int unsigned j;
      r.interval = $urandom;
      r.action_tag = 8'($urandom);
      r.handle = $urandom;
      r.now = $urandom;
      sel = $urandom_range(99);
      if (sel < 40) begin
         r.cmd = ($urandom_range(1) == 1) ? CMD_REPEAT : CMD_ONE_SHOT;
         if ($urandom_range(9) != 0) begin
            r.interval = $urandom_range(60);
         end
      end else if (sel < 60) begin
         r.cmd = CMD_CANCEL;
         j = $urandom_range(NUM_SLOTS - 1);
         if (slot_live[j] && $urandom_range(4) != 0) begin
            r.handle = slot_hdl[j];
         end else if ($urandom_range(1) == 1) begin
            r.handle = hdl_count - 32'($urandom_range(3));
         end
      end else begin
         r.cmd = CMD_DISPATCH;
         if ($urandom_range(9) != 0) begin
            r.now = cur_time + 32'($urandom_range(40));
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected result", '0, rsp_data);
            end else begin
               sts_rsp_type want;
               want = expected_q.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.timer_handle !== want.timer_handle ||
                   rsp_data.fired_tag !== want.fired_tag || rsp_data.ok !== want.ok ||
                   rsp_data.last !== want.last) begin
                  report_mismatch("wrong result", want, rsp_data);
               end
            end
         end
         if (start && !busy) begin
            timer_table_step(req_data);
            if (pin_valid) begin
               void'(expected_q.pop_back());
               expected_q.push_back(pin_rsp);
            end
         end
         if (psel && penable && pwrite && pready && paddr == SLOTS_ADDR) begin
            slots_reg = pwdata[4:0];
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic issue(input sts_req_type r, input logic pinned, input sts_rsp_type want);
      req_data <= r;
      pin_valid <= pinned;
      pin_rsp <= want;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (busy || expected_q.size() != 0);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic write_slots(input logic [4:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= SLOTS_ADDR;
      pwdata <= {27'($urandom), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      logic [4:0]  slots_now;
      logic [4:0]  phase_slots [9];
      int          burst_left;
      sts_rsp_type none;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      pin_valid = 1'b0;
      pin_rsp = '0;
      none = '0;
      mismatch_count = 0;
      idle_cycles = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_live[i] = 1'b0;
         slot_hdl[i] = '0;
         slot_due[i] = '0;
         slot_per[i] = '0;
         slot_tg[i] = '0;
      end
      hdl_count = '0;
      cur_time = '0;
      slots_reg = SLOTS_REG_RESET;
      slots_now = SLOTS_REG_RESET;

      stim_rows = '{
         row(5'd16, CMD_CANCEL,   32'd0,        8'h00, 32'd0,        32'd0,
             1'b1, KIND_CANCEL, 32'd0, 1'b0),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'd0,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_ONE_SHOT, 32'd0,        8'h00, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd1, 1'b1),
         row(5'd16, CMD_REPEAT,   32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
             1'b1, KIND_CREATE, 32'd2, 1'b1),
         row(5'd16, CMD_REPEAT,   32'd0,        8'h5A, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd3, 1'b1),
         row(5'd16, CMD_ONE_SHOT, 32'd10,       8'h81, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd4, 1'b1),
         row(5'd16, CMD_CANCEL,   32'd0,        8'h00, 32'd2,        32'd0,
             1'b1, KIND_CANCEL, 32'd0, 1'b1),
         row(5'd16, CMD_CANCEL,   32'd0,        8'h00, 32'd2,        32'd0,
             1'b1, KIND_CANCEL, 32'd0, 1'b0),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'd0,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'd1,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'hFFFFFFFF,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_ONE_SHOT, 32'd5,        8'hC3, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd5, 1'b1),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'd5,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_REPEAT,   32'd3,        8'h33, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd6, 1'b1),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'hFFFFFFFF,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'hFFFFFFFF,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd16, CMD_CANCEL,   32'd0,        8'h00, 32'd6,        32'd0,
             1'b1, KIND_CANCEL, 32'd0, 1'b1),
         row(5'd16, CMD_CANCEL,   32'd0,        8'h00, 32'hFFFFFFFF, 32'd0,
             1'b1, KIND_CANCEL, 32'd0, 1'b0),
         row(5'd1,  CMD_ONE_SHOT, 32'd100,      8'h11, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd7, 1'b1),
         row(5'd1,  CMD_REPEAT,   32'd1,        8'h22, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd0, 1'b1),
         row(5'd0,  CMD_ONE_SHOT, 32'd1,        8'h44, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd0, 1'b1),
         row(5'd0,  CMD_DISPATCH, 32'd0,        8'h00, 32'd0,        32'hFFFFFFFF,
             1'b0, KIND_FIRED,  32'd0, 1'b1),
         row(5'd31, CMD_ONE_SHOT, 32'd1,        8'h7E, 32'd0,        32'd0,
             1'b1, KIND_CREATE, 32'd8, 1'b1),
         row(5'd31, CMD_CANCEL,   32'd0,        8'h00, 32'd8,        32'd0,
             1'b1, KIND_CANCEL, 32'd0, 1'b1)
      };
      phase_slots = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd17, 5'd16, 5'd8, 5'($urandom)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].slots != slots_now) begin
            start <= 1'b0;
            wait_idle();
            write_slots(stim_rows[i].slots);
            slots_now = stim_rows[i].slots;
         end
         issue(stim_rows[i].req, stim_rows[i].pinned, stim_rows[i].rsp);
      end

      foreach (phase_slots[p]) begin
         start <= 1'b0;
         wait_idle();
         write_slots(phase_slots[p]);
         burst_left = 0;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (burst_left == 0) begin
               start <= 1'b0;
               repeat ($urandom_range(1, 24)) @(posedge clock);
               burst_left = $urandom_range(1, 10);
            end
            issue(random_request(), 1'b0, none);
            burst_left--;
         end
      end

      start <= 1'b0;
      wait_idle();
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== software_timer_slot_table.f =====
rtl/sts_pkg.sv
rtl/sts_slot_mem.sv
rtl/sts_slot_alu.sv
rtl/software_timer_slot_table.sv
tb/tb_top.sv
